>>> hdl/alist_pkg.sv
`default_nettype none
package alist_pkg;

  localparam int CAPACITY_DEFAULT = 16;
  localparam int WORD_W = 32;
  localparam int INDEX_W = 4;
  localparam int COUNT_W = 5;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // broadcast to every cell on the cycle a word is taken
  typedef struct packed {
    logic                 take;
    cmd_t                 cmd;
    logic [WORD_W-1:0]    value;
    logic [INDEX_W-1:0]   index;
  } cell_ctl_t;

endpackage
`default_nettype wire

>>> hdl/compacting_array_list.sv
// Fixed-capacity ordered list of 32-bit words, one cell per entry.
// Input channel (in_valid/in_ready) takes a command word: cmd, value, index.
// Append writes at the tail, remove shifts all later cells down one place in
// the same cycle, get selects one cell, search compares in every cell at once.
// Output channel (out_valid/out_ready) returns status, data, found_index and
// the fill count after the command.
// The cells register compare/select at the accepting edge, and the reduce
// lands in the output register when that stage moves on, raising out_valid.
// Throughput: one command per cycle while the receiver keeps out_ready
// high; the cells act on a command at the edge it is taken, so the next one
// sees the updated list.
// If the receiver stalls, the output register and the compare stage both
// hold, and in_ready drops once both are full; nothing is lost.
// Reset (rst, synchronous) empties the list: fill count zero, no results
// pending. Entry contents are not cleared; only filled positions are read.
`default_nettype none
module compacting_array_list #(
  parameter int CAPACITY = alist_pkg::CAPACITY_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    cmd,
  input  wire logic signed [alist_pkg::WORD_W-1:0]  value,
  input  wire logic [alist_pkg::INDEX_W-1:0] index,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         status,
  output logic signed [alist_pkg::WORD_W-1:0] data,
  output logic [alist_pkg::INDEX_W-1:0]      found_index,
  output logic [alist_pkg::COUNT_W-1:0]      count
);
  import alist_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [CW-1:0] fill;
  logic [CW-1:0] fill_next;
  logic          s1_valid;
  cmd_t          s1_cmd;
  status_t       s1_status;
  logic [CW-1:0] s1_count;
  status_t       st_next;
  cell_ctl_t     ctl;
  logic          take;
  logic          move;
  logic          in_range;

  logic [CAPACITY-1:0]             match;
  logic [CAPACITY-1:0][WORD_W-1:0] rd;
  logic [CAPACITY:0][WORD_W-1:0]   link;
  logic                            found;
  logic [IW-1:0]                   fidx;
  logic [WORD_W-1:0]               rd_data;

  assign move     = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || move;
  assign take     = in_valid && in_ready;
  assign in_range = XW'(index) < XW'(fill);

  assign ctl.take  = take;
  assign ctl.cmd   = cmd_t'(cmd);
  assign ctl.value = value;
  assign ctl.index = index;

  always_comb begin
    fill_next = fill;
    st_next   = ST_OK;
    case (cmd_t'(cmd))
      CMD_APPEND: begin
        if (fill < CAP_C) fill_next = fill + CW'(1);
        else st_next = ST_FULL;
      end
      CMD_REMOVE: begin
        if (in_range) fill_next = fill - CW'(1);
        else st_next = ST_RANGE;
      end
      CMD_GET: begin
        if (!in_range) st_next = ST_RANGE;
      end
      default: st_next = ST_OK;
    endcase
  end

  assign link[CAPACITY] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    alist_cell #(.CAPACITY(CAPACITY), .POS(i)) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .fill   (fill),
      .upper  (link[i+1]),
      .match  (match[i]),
      .rd     (rd[i]),
      .stored (link[i])
    );
  end

  alist_reduce #(.CAPACITY(CAPACITY)) u_reduce (
    .match (match),
    .rd    (rd),
    .found (found),
    .fidx  (fidx),
    .data  (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        fill <= fill_next;
      end
      if (take) s1_valid <= 1'b1;
      else if (move) s1_valid <= 1'b0;
      if (move) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_cmd    <= cmd_t'(cmd);
      s1_status <= st_next;
      s1_count  <= fill_next;
    end
    if (move) begin
      count       <= COUNT_W'(s1_count);
      found_index <= '0;
      data        <= '0;
      status      <= s1_status;
      if (s1_status == ST_RANGE) begin
        data <= '1;
      end else if (s1_cmd == CMD_GET) begin
        data <= rd_data;
      end else if (s1_cmd == CMD_SEARCH) begin
        if (found) begin
          status      <= ST_OK;
          found_index <= INDEX_W'(fidx);
        end else begin
          status <= ST_NOTFOUND;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/alist_cell.sv
`default_nettype none
module alist_cell #(
  parameter int CAPACITY = alist_pkg::CAPACITY_DEFAULT,
  parameter int POS = 0
) (
  input  wire logic                          clk,
  input  wire alist_pkg::cell_ctl_t          ctl,
  input  wire logic [$clog2(CAPACITY+1)-1:0] fill,
  input  wire logic [alist_pkg::WORD_W-1:0]  upper,
  output logic                               match,
  output logic [alist_pkg::WORD_W-1:0]       rd,
  output logic [alist_pkg::WORD_W-1:0]       stored
);
  import alist_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;
  localparam logic [XW-1:0] POS_X = XW'(POS);

  logic [WORD_W-1:0] entry;
  logic [XW-1:0]     idx_x;
  logic [XW-1:0]     fill_x;
  logic              held;
  logic              wr_en;
  logic              shift_en;

  assign idx_x  = XW'(ctl.index);
  assign fill_x = XW'(fill);
  assign held   = POS_X < fill_x;
  assign wr_en    = ctl.take && (ctl.cmd == CMD_APPEND) && (fill_x == POS_X);
  // remove: every cell from the index up to the one below the tail pulls from above
  assign shift_en = ctl.take && (ctl.cmd == CMD_REMOVE) && (idx_x <= POS_X)
                    && (POS_X + XW'(1) < fill_x);
  // handed to the cell below for a remove
  assign stored = entry;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry <= ctl.value;
    end else if (shift_en) begin
      entry <= upper;
    end
    if (ctl.take) begin
      match <= held && (entry == ctl.value);
      rd    <= (idx_x == POS_X) ? entry : '0;
    end
  end

endmodule
`default_nettype wire

>>> hdl/alist_reduce.sv
`default_nettype none
module alist_reduce #(
  parameter int CAPACITY = alist_pkg::CAPACITY_DEFAULT
) (
  input  wire logic [CAPACITY-1:0]                   match,
  input  wire logic [CAPACITY-1:0][alist_pkg::WORD_W-1:0] rd,
  output logic                                       found,
  output logic [$clog2(CAPACITY)-1:0]                fidx,
  output logic [alist_pkg::WORD_W-1:0]               data
);
  import alist_pkg::*;

  localparam int IW = $clog2(CAPACITY);

  // lowest matching position wins
  always_comb begin
    fidx = '0;
    data = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        fidx = IW'(i);
      end
    end
    for (int i = 0; i < CAPACITY; i++) begin
      data = data | rd[i];
    end
  end

  assign found = |match;

endmodule
`default_nettype wire
